// ----- sv/grle_pkg.sv -----
package grle_pkg;

	// stream parse mode
	typedef enum logic [1:0] {
		MODE_HEADER  = 2'd0,
		MODE_REPEAT  = 2'd1,
		MODE_LITERAL = 2'd2,
		MODE_PAD     = 2'd3
	} mode_t;

	// controller sequencing
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_RUN   = 2'd1,
		ST_FLUSH = 2'd2,
		ST_EMPTY = 2'd3
	} state_t;

	typedef enum logic {
		ACT_DATA   = 1'b0,
		ACT_FINISH = 1'b1
	} action_t;

	// register indexes
	localparam logic [0:0] CFG_WIDTH  = 1'b0;
	localparam logic [0:0] CFG_HEIGHT = 1'b1;

	localparam int unsigned PIX_W       = 8;
	localparam int unsigned PIX_PER_RES = 4;
	localparam int unsigned CNT_W       = 3;
	// padding stops once this many pixels went out for one finish request
	localparam logic [8:0]  PAD_PIX_LIMIT = 9'd255;
	localparam int unsigned HDR_REP_BIT   = 7;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic hdr_rep;    // load run length from header
		logic hdr_lit;    // load literal count from header
		logic lit_dec;    // one literal byte consumed
		logic lit_cnt;    // literal run is a single byte
		logic clr_run;    // drop pending run length
		logic load_byte;  // latch data byte, open a new request
		logic start_pad;  // latch zero byte, open a padding request
		logic step;       // place one packed byte
		logic pad;        // current request is padding
		logic flush;      // send leftover pixel
		logic empty;      // send empty done result
		logic rearm;      // clear glyph position and counts
	} cmd_t;

	typedef struct packed {
		logic full;
		logic hdr_rep;
		logic hdr_zero;
		logic lit_one;
		logic last_byte;
		logic full_after;
		logic flush_needed;
		logic out_free;
	} sts_t;

	// 4-bit coverage times 17 is the nibble repeated
	function automatic pix_t pix_widen(input logic [3:0] nib);
		pix_widen = {nib, nib};
	endfunction

endpackage

// ----- sv/grle_ctrl.sv -----
module grle_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_action,
	output logic           in_ready,
	input  grle_pkg::sts_t sts,
	output grle_pkg::cmd_t cmd
);
	import grle_pkg::*;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic   in_fire;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_HEADER;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_action == ACT_FINISH) begin
						if (sts.full) begin
							mode_d  = MODE_HEADER;
							state_d = ST_EMPTY;
						end else begin
							mode_d  = MODE_PAD;
							state_d = ST_RUN;
						end
					end else begin
						case (mode_q)
							MODE_HEADER: begin
								if (sts.hdr_rep) mode_d = MODE_REPEAT;
								else if (!sts.hdr_zero) mode_d = MODE_LITERAL;
							end
							MODE_REPEAT: begin
								mode_d = MODE_HEADER;
								if (!sts.full) state_d = ST_RUN;
							end
							MODE_LITERAL: begin
								if (sts.lit_one) mode_d = MODE_HEADER;
								if (!sts.full) state_d = ST_RUN;
							end
							default: ;
						endcase
					end
				end
			end
			ST_RUN: begin
				if (sts.out_free && sts.last_byte) begin
					if (mode_q == MODE_PAD && sts.full_after) mode_d = MODE_HEADER;
					state_d = sts.flush_needed ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			ST_EMPTY: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.pad = (mode_q == MODE_PAD);
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_action == ACT_FINISH) begin
						if (sts.full) cmd.rearm = 1'b1;
						else cmd.start_pad = 1'b1;
					end else begin
						case (mode_q)
							MODE_HEADER: begin
								cmd.hdr_rep = sts.hdr_rep;
								cmd.hdr_lit = !sts.hdr_rep && !sts.hdr_zero;
							end
							MODE_REPEAT: begin
								cmd.load_byte = 1'b1;
								cmd.clr_run   = sts.full;
							end
							MODE_LITERAL: begin
								cmd.load_byte = 1'b1;
								cmd.lit_dec   = 1'b1;
								cmd.lit_cnt   = !sts.full;
							end
							default: ;
						endcase
					end
				end
			end
			ST_RUN: begin
				cmd.step  = sts.out_free;
				cmd.rearm = sts.out_free && sts.last_byte &&
					(mode_q == MODE_PAD) && sts.full_after;
			end
			ST_FLUSH: cmd.flush = sts.out_free;
			ST_EMPTY: cmd.empty = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ----- sv/grle_dp.sv -----
module grle_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [0:0]     cfg_idx,
	input  logic [7:0]     cfg_data,
	input  logic [7:0]     in_byte,
	input  grle_pkg::cmd_t cmd,
	output grle_pkg::sts_t sts,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [39:0]    m_tdata,
	output logic           m_tlast,
	output logic           m_tuser
);
	import grle_pkg::*;

	logic [7:0] width_q, height_q;
	logic [6:0] col_q;
	logic [7:0] row_q;
	logic [6:0] lit_q;
	logic [7:0] run_q;
	logic [8:0] npix_q;
	logic [7:0] byte_q;
	logic       done_q;

	// partial result of the current request
	pix_t       pk_q [PIX_PER_RES];
	logic [1:0] fill_q;

	// output register
	logic             ov_q;
	pix_t             opix_q [PIX_PER_RES];
	logic [CNT_W-1:0] ocnt_q;
	logic             olast_q, odone_q;

	logic [8:0]       w_inc;
	logic [7:0]       stride, row_inc, row_nxt;
	logic             last_col, two, full_now, full_after, last_byte;
	logic [8:0]       npix_after;
	logic [2:0]       tot;
	pix_t             p_lo, p_hi;
	pix_t             comb_pix [PIX_PER_RES+1];
	logic             emit, run_last_now, done_now, out_free;
	logic [CNT_W-1:0] rcnt;

	assign w_inc    = {1'b0, width_q} + 9'd1;
	assign stride   = w_inc[8:1];
	assign last_col = ({1'b0, col_q} + 8'd1) >= stride;
	assign two      = !(last_col && width_q[0]);
	assign row_inc  = row_q + 8'd1;
	assign row_nxt  = last_col ? row_inc : row_q;

	assign full_now   = (width_q == 8'd0) || (height_q == 8'd0) || (row_q >= height_q);
	assign full_after = (width_q == 8'd0) || (height_q == 8'd0) || (row_nxt >= height_q);

	assign npix_after = npix_q + (two ? 9'd2 : 9'd1);
	assign last_byte  = cmd.pad ? (full_after || npix_after >= PAD_PIX_LIMIT)
	                            : (run_q == 8'd1 || full_after);

	assign p_lo = pix_widen(byte_q[3:0]);
	assign p_hi = pix_widen(byte_q[7:4]);
	assign tot  = {1'b0, fill_q} + (two ? 3'd2 : 3'd1);

	// merge new pixels behind the held ones
	always_comb begin
		for (int i = 0; i <= PIX_PER_RES; i++) begin
			if (3'(i) == {1'b0, fill_q}) comb_pix[i] = p_lo;
			else if (two && 3'(i) == ({1'b0, fill_q} + 3'd1)) comb_pix[i] = p_hi;
			else if (i < PIX_PER_RES) comb_pix[i] = pk_q[i];
			else comb_pix[i] = '0;
		end
	end

	assign emit         = (tot >= 3'd4) || last_byte;
	assign rcnt         = (tot >= 3'd4) ? 3'd4 : tot;
	assign run_last_now = last_byte && (tot <= 3'd4);
	assign done_now     = cmd.pad && full_after;
	assign out_free     = !ov_q || m_tready;

	always_comb begin
		sts              = '0;
		sts.full         = full_now;
		sts.hdr_rep      = in_byte[HDR_REP_BIT];
		sts.hdr_zero     = (in_byte == 8'd0);
		sts.lit_one      = (lit_q == 7'd1);
		sts.last_byte    = last_byte;
		sts.full_after   = full_after;
		sts.flush_needed = last_byte && (tot == 3'd5);
		sts.out_free     = out_free;
	end

	// config and glyph position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			lit_q    <= '0;
			run_q    <= '0;
			npix_q   <= '0;
			fill_q   <= '0;
			done_q   <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.hdr_rep) run_q <= 8'd0 - in_byte;
			if (cmd.hdr_lit) lit_q <= in_byte[6:0];
			if (cmd.lit_dec) lit_q <= lit_q - 7'd1;
			if (cmd.lit_cnt) run_q <= 8'd1;
			if (cmd.clr_run) run_q <= '0;
			if (cmd.load_byte || cmd.start_pad) npix_q <= '0;
			if (cmd.step) begin
				if (!cmd.pad) run_q <= run_q - 8'd1;
				npix_q <= npix_after;
				done_q <= done_now;
				if (tot >= 3'd4) fill_q <= tot[1:0];
				else if (last_byte) fill_q <= '0;
				else fill_q <= tot[1:0];
			end
			if (cmd.flush) fill_q <= '0;
			// rearm wins over the position step of the same cycle
			if (cmd.rearm) begin
				col_q <= '0;
				row_q <= '0;
				lit_q <= '0;
				run_q <= '0;
			end else if (cmd.step) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= row_inc;
				end else begin
					col_q <= col_q + 7'd1;
				end
			end
			if ((cmd.step && emit) || cmd.flush || cmd.empty) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_byte) byte_q <= in_byte;
		if (cmd.start_pad) byte_q <= '0;
		if (cmd.step) begin
			if (tot >= 3'd4) pk_q[0] <= comb_pix[PIX_PER_RES];
			else for (int i = 0; i < PIX_PER_RES; i++) pk_q[i] <= comb_pix[i];
		end
		if (cmd.step && emit) begin
			for (int i = 0; i < PIX_PER_RES; i++)
				opix_q[i] <= (3'(i) < rcnt) ? comb_pix[i] : '0;
			ocnt_q  <= rcnt;
			olast_q <= run_last_now;
			odone_q <= run_last_now && done_now;
		end else if (cmd.flush) begin
			opix_q[0] <= pk_q[0];
			for (int i = 1; i < PIX_PER_RES; i++) opix_q[i] <= '0;
			ocnt_q  <= 3'd1;
			olast_q <= 1'b1;
			odone_q <= done_q;
		end else if (cmd.empty) begin
			for (int i = 0; i < PIX_PER_RES; i++) opix_q[i] <= '0;
			ocnt_q  <= 3'd0;
			olast_q <= 1'b1;
			odone_q <= 1'b1;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {5'd0, ocnt_q, opix_q[3], opix_q[2], opix_q[1], opix_q[0]};
	assign m_tlast  = olast_q;
	assign m_tuser  = odone_q;

endmodule

// ----- sv/glyph_rle_nibble_decoder.sv -----
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: data_byte; tuser: action
// m_*       out  m_tvalid/m_tready  tdata: pixel_0..3, pixel_count; tlast: run_last;
//                                   tuser: glyph_done
// cfg_*     in   cfg_we             cfg_idx selects width (0) or height (1)
//
// A header byte, an ignored byte or a data byte on a full glyph is only accepted.
// A literal byte is accepted and then placed as one packed byte. A finish on a
// full glyph is accepted and then answered with the empty done result.
// Repeat runs place up to 128 packed bytes and padding up to 255 (one pixel per
// byte at width one), one byte per cycle while the output register is free;
// any leftover pixel is flushed last. The longest request is 255 padding bytes.
// Reset clears the parse mode, glyph position and both size registers.
// A full output register stalls placement until m_tready takes the result.
module glyph_rle_nibble_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// input requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] action: 0 data byte, 1 finish glyph
	// pixel results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] pixel_0, [15:8] pixel_1, [23:16] pixel_2,
	                               // [31:24] pixel_3, [34:32] pixel_count, rest zero
	output logic        m_tlast,   // run_last: last result of the input request
	output logic        m_tuser,   // [0] glyph_done
	// register writes
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [7:0]  cfg_data
);
	import grle_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// parse mode and sequencing
	grle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (s_tuser),
		.in_ready  (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// counters, pixel packing and output register
	grle_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_byte  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
